// ===== design/pal_pkg.sv =====
package pal_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_BADPOS  = 2'd2
  } status_t;

  // broadcast to every cell in the accept cycle
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== design/pal_cell.sv =====
module pal_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 5
) (
  input  logic                      clk,
  input  pal_pkg::cell_ctrl_t       ctrl,
  input  logic [pal_pkg::WORD_W-1:0] word,
  input  logic [pal_pkg::WORD_W-1:0] left,
  input  logic [pal_pkg::WORD_W-1:0] right,
  output logic [pal_pkg::WORD_W-1:0] value,
  output logic [pal_pkg::WORD_W-1:0] tap
);

  logic [IDX_W-1:0] my_idx;
  logic [IDX_W-1:0] pos_ext;
  logic             at_pos;
  logic             above_pos;
  logic [pal_pkg::WORD_W-1:0] value_next;

  assign my_idx    = IDX_W'(IDX);
  assign pos_ext   = IDX_W'(ctrl.pos);
  assign at_pos    = (my_idx == pos_ext);
  assign above_pos = (my_idx > pos_ext);

  // entries past the length may take junk from a neighbor; they are never read
  always_comb begin
    value_next = value;
    if (ctrl.ins_en) begin
      if (at_pos) begin
        value_next = word;
      end else if (above_pos) begin
        value_next = left;
      end
    end else if (ctrl.del_en) begin
      if (at_pos || above_pos) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign tap = at_pos ? value : '0;

endmodule

// ===== design/positional_array_list.sv =====
// positional array list: an ordered list of up to MAX_ENTRIES signed words.
// command channel: func, position and item are taken at a rising edge where
// start is high and busy is low. func selects insert at position, delete at
// position (returns the removed word) or read at position.
// result channel: done is high for exactly one cycle, the cycle after the
// command was taken, with data, status, count, empty_res and full_res.
// latency is one cycle and a new command may be taken in every cycle: each
// cell of the row compares its own index with the position and shifts with
// its neighbor in the same edge, so the row updates in one cycle whatever
// the position; the read word comes from an and-or over the cell taps.
// refused commands (full list, bad position, unknown func) leave the list
// untouched and report it in status.
// reset (rst, synchronous) empties the list; busy is high while rst is high.
// entry contents are not cleared; a slot is read only after an insert.
// the receiver cannot stall: a result is shown once and then gone.
module positional_array_list #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [4:0]  position,
  input  logic signed [31:0] item,
  output logic        done,
  output logic signed [31:0] data,
  output logic [1:0]  status,
  output logic [4:0]  count,
  output logic        empty_res,
  output logic        full_res
);

  localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (LEN_W > pal_pkg::POS_W) ? LEN_W : pal_pkg::POS_W;
  localparam int IDX_W = ($clog2(MAX_ENTRIES) > pal_pkg::POS_W) ?
                         $clog2(MAX_ENTRIES) : pal_pkg::POS_W;

  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  logic             accept;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] len_c;
  logic             full_now;
  logic             ins_ok;
  logic             del_ok;
  logic             rd_ok;
  logic [1:0]       status_next;
  logic [pal_pkg::WORD_W-1:0] sel_word;
  pal_pkg::cell_ctrl_t ctrl;

  logic [pal_pkg::WORD_W-1:0] value [MAX_ENTRIES];
  logic [pal_pkg::WORD_W-1:0] tap   [MAX_ENTRIES];

  assign busy   = rst;
  assign accept = start && !busy;

  assign pos_c    = CMP_W'(position);
  assign len_c    = CMP_W'(length);
  assign full_now = (length == LEN_W'(MAX_ENTRIES));

  assign ins_ok = accept && (func == pal_pkg::FUNC_INSERT) && !full_now && (pos_c <= len_c);
  assign del_ok = accept && (func == pal_pkg::FUNC_DELETE) && (pos_c < len_c);
  assign rd_ok  = accept && (func == pal_pkg::FUNC_READ) && (pos_c < len_c);

  assign ctrl.ins_en = ins_ok;
  assign ctrl.del_en = del_ok;
  assign ctrl.pos    = position;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic [pal_pkg::WORD_W-1:0] left_w;
      logic [pal_pkg::WORD_W-1:0] right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = value[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_last
        assign right_w = value[gi];
      end else begin : g_mid_r
        assign right_w = value[gi+1];
      end
      pal_cell #(
        .IDX   (gi),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .word  (item),
        .left  (left_w),
        .right (right_w),
        .value (value[gi]),
        .tap   (tap[gi])
      );
    end
  endgenerate

  // at most one tap is nonzero
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_word = sel_word | tap[i];
    end
  end

  always_comb begin
    length_next = length;
    if (ins_ok) begin
      length_next = length + LEN_W'(1);
    end else if (del_ok) begin
      length_next = length - LEN_W'(1);
    end
  end

  always_comb begin
    if (func == pal_pkg::FUNC_INSERT) begin
      status_next = ins_ok ? pal_pkg::ST_DONE : pal_pkg::ST_REFUSED;
    end else if (del_ok || rd_ok) begin
      status_next = pal_pkg::ST_DONE;
    end else begin
      status_next = pal_pkg::ST_BADPOS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
    end else begin
      length <= length_next;
      done   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data      <= (del_ok || rd_ok) ? sel_word : '0;
      status    <= status_next;
      count     <= 5'(length_next);
      empty_res <= (length_next == '0);
      full_res  <= (length_next == LEN_W'(MAX_ENTRIES));
    end
  end

endmodule

// ===== design/pal_checker.sv =====
module pal_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func,
  input logic        done,
  input logic [31:0] data,
  input logic [1:0]  status,
  input logic [4:0]  count,
  input logic        empty_res,
  input logic        full_res
);

  // one result per taken command, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after a taken command");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a command");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == pal_pkg::ST_REFUSED || status == pal_pkg::ST_BADPOS)) |-> (data == '0))
    else $error("refused command returned data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && empty_res) |-> (count == '0 && !full_res))
    else $error("empty flag disagrees with count");

  // back-to-back successful insert grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && status == pal_pkg::ST_DONE
      && $past(func) == pal_pkg::FUNC_INSERT && $past(start && !busy))
      |-> (count == 5'($past(count) + 5'd1)))
    else $error("insert did not grow the list");

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .func      (func),
  .done      (done),
  .data      (data),
  .status    (status),
  .count     (count),
  .empty_res (empty_res),
  .full_res  (full_res)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH = 16;
  localparam int RAND_WORDS = 450;
  localparam int PLAN_LEN = 25;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [31:0]      data;
    pal_pkg::status_t status;
    logic [4:0]       count;
    logic             empty;
    logic             full;
  } answer_t;

  typedef struct packed {
    logic [1:0]  f;
    logic [4:0]  pos;
    logic [31:0] word;
    logic [4:0]  reps;
    logic        typed;
    answer_t     ans;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = pal_pkg::FUNC_INSERT;
  logic [4:0] position = '0;
  logic signed [31:0] item = '0;
  logic busy, done, empty_res, full_res;
  logic signed [31:0] data;
  logic [1:0] status;
  logic [4:0] count;

  // typed-in expectation that travels with the word being offered
  logic    typed_hold = 1'b0;
  answer_t typed_ans = '0;

  logic [31:0] list_words [DEPTH];
  int list_len = 0;
  answer_t answer_q [$];
  bit took = 1'b0;
  int fails = 0;
  int n_words = 0, n_ins = 0, n_del = 0, n_rd = 0, n_rej = 0, n_full = 0;

  step_t plan [PLAN_LEN] = '{
    '{pal_pkg::FUNC_READ,   5'd0,  32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd0, 1'b1, 1'b0}},
    '{pal_pkg::FUNC_DELETE, 5'd0,  32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd0, 1'b1, 1'b0}},
    '{pal_pkg::FUNC_INSERT, 5'd1,  32'd5,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_REFUSED, 5'd0, 1'b1, 1'b0}},
    '{FUNC_NONE,            5'd0,  32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd0, 1'b1, 1'b0}},
    '{pal_pkg::FUNC_INSERT, 5'd0,  32'h7fffffff, 5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_DONE,    5'd1, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_INSERT, 5'd0,  32'h80000000, 5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_DONE,    5'd2, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_READ,   5'd0,  32'd0,        5'd1,  1'b1,
      '{32'h80000000, pal_pkg::ST_DONE, 5'd2, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_READ,   5'd1,  32'hffffffff, 5'd1,  1'b1,
      '{32'h7fffffff, pal_pkg::ST_DONE, 5'd2, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_INSERT, 5'd2,  32'hffffffff, 5'd1,  1'b0, '0},
    '{pal_pkg::FUNC_INSERT, 5'd1,  32'd0,        5'd1,  1'b0, '0},
    '{pal_pkg::FUNC_INSERT, 5'd31, 32'd9,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_REFUSED, 5'd4, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_INSERT, 5'd5,  32'd9,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_REFUSED, 5'd4, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_READ,   5'd4,  32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd4, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_DELETE, 5'd31, 32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd4, 1'b0, 1'b0}},
    '{pal_pkg::FUNC_DELETE, 5'd1,  32'd0,        5'd1,  1'b0, '0},
    '{FUNC_NONE,            5'd2,  32'd0,        5'd1,  1'b0, '0},
    // fill to the top from the front
    '{pal_pkg::FUNC_INSERT, 5'd0,  32'h12345678, 5'd13, 1'b0, '0},
    '{pal_pkg::FUNC_INSERT, 5'd0,  32'd1,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_REFUSED, 5'd16, 1'b0, 1'b1}},
    '{pal_pkg::FUNC_INSERT, 5'd16, 32'd1,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_REFUSED, 5'd16, 1'b0, 1'b1}},
    '{pal_pkg::FUNC_READ,   5'd15, 32'd0,        5'd1,  1'b0, '0},
    '{pal_pkg::FUNC_READ,   5'd16, 32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd16, 1'b0, 1'b1}},
    '{pal_pkg::FUNC_DELETE, 5'd15, 32'd0,        5'd1,  1'b0, '0},
    '{pal_pkg::FUNC_DELETE, 5'd0,  32'd0,        5'd1,  1'b0, '0},
    '{pal_pkg::FUNC_READ,   5'd7,  32'd0,        5'd1,  1'b0, '0},
    '{pal_pkg::FUNC_DELETE, 5'd14, 32'd0,        5'd1,  1'b1,
      '{32'd0, pal_pkg::ST_BADPOS,  5'd14, 1'b0, 1'b0}}
  };

  positional_array_list #(.MAX_ENTRIES(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .position(position), .item(item),
    .done(done), .data(data), .status(status), .count(count),
    .empty_res(empty_res), .full_res(full_res)
  );

  always #1 clk = ~clk;

  function automatic answer_t list_apply(input logic [1:0] f, input logic [4:0] p,
                                         input logic [31:0] w);
    answer_t a;
    int pi;
    int k;
    pi = p;
    a = '0;
    a.status = pal_pkg::ST_DONE;
    case (f)
      pal_pkg::FUNC_INSERT: begin
        if (list_len >= DEPTH || pi > list_len) begin
          a.status = pal_pkg::ST_REFUSED;
        end else begin
          for (k = list_len; k > pi; k--) list_words[k] = list_words[k-1];
          list_words[pi] = w;
          list_len++;
        end
      end
      pal_pkg::FUNC_DELETE: begin
        if (pi >= list_len) begin
          a.status = pal_pkg::ST_BADPOS;
        end else begin
          a.data = list_words[pi];
          for (k = pi; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      pal_pkg::FUNC_READ: begin
        if (pi >= list_len) a.status = pal_pkg::ST_BADPOS;
        else a.data = list_words[pi];
      end
      default: a.status = pal_pkg::ST_BADPOS;
    endcase
    a.count = list_len[4:0];
    a.empty = (list_len == 0);
    a.full = (list_len == DEPTH);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && done === 1'b1) begin
      got = '{data, pal_pkg::status_t'(status), count, empty_res, full_res};
      if (answer_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: data %0d status %0d count %0d",
                                  $signed(got.data), got.status, got.count);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: want data %0d st %0d cnt %0d e %b f %b, got %0d %0d %0d %b %b",
                     $signed(want.data), want.status, want.count, want.empty, want.full,
                     $signed(got.data), got.status, got.count, got.empty, got.full);
        end
      end
    end
    took = start && !busy;
    if (took) begin
      want = list_apply(func, position, item);
      n_words++;
      if (want.status != pal_pkg::ST_DONE) n_rej++;
      else if (func == pal_pkg::FUNC_INSERT) n_ins++;
      else if (func == pal_pkg::FUNC_DELETE) n_del++;
      else n_rd++;
      if (want.full) n_full++;
      if (typed_hold) want = typed_ans;
      answer_q.push_back(want);
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [1:0] f, input logic [4:0] p, input logic [31:0] w,
                           input logic typed, input answer_t ta);
    start <= 1'b1;
    func <= f;
    position <= p;
    item <= w;
    typed_hold <= typed;
    typed_ans <= ta;
    do @(negedge clk); while (!took);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_all_back();
    start <= 1'b0;
    do @(negedge clk); while (answer_q.size() != 0);
  endtask

  initial begin
    int i, r, sent, burst, roll, k;
    bit filling, paused;
    logic [1:0] f;
    logic [4:0] p;
    logic [31:0] w;
    filling = 1'b1;
    paused = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < PLAN_LEN; i++) begin
      for (r = 0; r < plan[i].reps; r++)
        send_word(plan[i].f, plan[i].pos, plan[i].word + r, plan[i].typed, plan[i].ans);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
    end
    wait_all_back();

    sent = 0;
    while (sent < RAND_WORDS) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < RAND_WORDS; k++) begin
        // swing between filling and draining so both ends get hit often
        if (list_len == DEPTH) filling = 1'b0;
        else if (list_len == 0) filling = 1'b1;
        else if ($urandom_range(0, 49) == 0) filling = !filling;
        roll = $urandom_range(0, 99);
        if (roll < 3) f = FUNC_NONE;
        else if (filling)
          f = roll < 60 ? pal_pkg::FUNC_INSERT :
              (roll < 80 ? pal_pkg::FUNC_DELETE : pal_pkg::FUNC_READ);
        else
          f = roll < 25 ? pal_pkg::FUNC_INSERT :
              (roll < 65 ? pal_pkg::FUNC_DELETE : pal_pkg::FUNC_READ);
        if ($urandom_range(0, 9) < 2) p = 5'($urandom_range(0, 31));
        else if (f == pal_pkg::FUNC_INSERT) p = 5'($urandom_range(0, list_len));
        else p = (list_len == 0) ? 5'd0 : 5'($urandom_range(0, list_len - 1));
        case ($urandom_range(0, 7))
          0: w = 32'h7fffffff;
          1: w = 32'h80000000;
          2: w = 32'h0;
          3: w = 32'hffffffff;
          default: w = $urandom;
        endcase
        send_word(f, p, w, 1'b0, '0);
        sent++;
      end
      if (!paused && sent >= RAND_WORDS / 2) begin
        wait_all_back();
        paused = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 7));
      end
    end

    wait_all_back();
    repeat (8) @(negedge clk);
    $display("ran %0d words: %0d inserts, %0d deletes, %0d reads done, %0d refused",
             n_words, n_ins, n_del, n_rd, n_rej);
    $display("list seen full after %0d words, %0d mismatches", n_full, fails);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/pal_pkg.sv
design/pal_cell.sv
design/positional_array_list.sv
design/pal_checker.sv
dv/testbench.sv
